// File: rtl/pba_pkg.sv
`timescale 1ns / 1ps

package pba_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int PAGE_W    = 15;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [OP_W-1:0]      op_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam word_t FULL_WORD = 32'hFFFF_FFFF;

  localparam op_t OP_ALLOC     = 2'd0;
  localparam op_t OP_FREE      = 2'd1;
  localparam op_t OP_MARK_FREE = 2'd2;
  localparam op_t OP_MARK_USED = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NO_FREE  = 2'd1;
  localparam status_t ST_NOT_USED = 2'd2;

  // Index of the lowest clear bit; a full word gives the top bit.
  function automatic bit_idx_t lowest_clear_bit(word_t w);
    bit_idx_t b;
    b = bit_idx_t'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        b = bit_idx_t'(i);
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/pba_map_ram.sv
`timescale 1ns / 1ps

module pba_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  pba_pkg::word_t     wr_data_i,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  output pba_pkg::word_t     rd_data_o
);

  pba_pkg::word_t mem [DEPTH];
  pba_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/pba_ctrl.sv
`timescale 1ns / 1ps

module pba_ctrl #(
  parameter int MAP_WORDS = 1024,
  parameter int AW        = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                start_i,
  input  pba_pkg::op_t        op_i,
  input  pba_pkg::page_t      page_index_i,
  output logic                busy_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  pba_pkg::word_t      rd_data_i,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output pba_pkg::word_t      wr_data_o,
  output logic                done_o,
  output pba_pkg::page_t      page_index_res_o,
  output pba_pkg::status_t    status_o
);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_e;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  state_e             state_q;
  pba_pkg::op_t       op_q;
  pba_pkg::page_t     page_q;
  logic [AW-1:0]      addr_q;
  logic [AW-1:0]      cnt_q;
  logic [AW-1:0]      hint_q;
  logic               done_q;
  pba_pkg::page_t     res_page_q;
  pba_pkg::status_t   status_q;

  logic [AW-1:0]      word_in;
  logic [AW-1:0]      addr_next;
  logic               in_map;
  logic               found;
  logic               last;
  logic               target_set;
  pba_pkg::bit_idx_t  lcb;
  pba_pkg::word_t     bit_mask;
  logic               accept;

  assign word_in    = AW'(page_index_i >> pba_pkg::BIT_W);
  assign addr_next  = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;
  assign in_map     = 32'(page_q >> pba_pkg::BIT_W) < 32'(MAP_WORDS);
  assign found      = rd_data_i != pba_pkg::FULL_WORD;
  assign last       = cnt_q == LAST_ADDR;
  assign lcb        = pba_pkg::lowest_clear_bit(rd_data_i);
  assign bit_mask   = pba_pkg::word_t'(1) << page_q[pba_pkg::BIT_W-1:0];
  assign target_set = in_map && ((rd_data_i & bit_mask) != '0);
  assign accept     = (state_q == S_IDLE) && start_i && en_i;
  assign busy_o     = state_q != S_IDLE;

  always_comb begin
    rd_en_o   = 1'b0;
    rd_addr_o = addr_next;
    if (state_q == S_IDLE) begin
      rd_en_o   = accept;
      rd_addr_o = (op_i == pba_pkg::OP_ALLOC) ? hint_q : word_in;
    end else if (op_q == pba_pkg::OP_ALLOC) begin
      rd_en_o = !found && !last;
    end
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = addr_q;
    wr_data_o = rd_data_i;
    if (state_q == S_EVAL) begin
      case (op_q)
        pba_pkg::OP_ALLOC: begin
          wr_en_o   = found;
          wr_data_o = rd_data_i | (pba_pkg::word_t'(1) << lcb);
        end
        pba_pkg::OP_FREE: begin
          wr_en_o   = target_set;
          wr_data_o = rd_data_i & ~bit_mask;
        end
        pba_pkg::OP_MARK_FREE: begin
          wr_en_o   = in_map;
          wr_data_o = rd_data_i & ~bit_mask;
        end
        default: begin
          wr_en_o   = in_map;
          wr_data_o = rd_data_i | bit_mask;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hint_q     <= '0;
      done_q     <= 1'b0;
      op_q       <= pba_pkg::OP_ALLOC;
      page_q     <= '0;
      addr_q     <= '0;
      cnt_q      <= '0;
      res_page_q <= '0;
      status_q   <= pba_pkg::ST_OK;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_i;
            page_q  <= page_index_i;
            addr_q  <= rd_addr_o;
            cnt_q   <= '0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_page_q <= '0;
          status_q   <= pba_pkg::ST_OK;
          case (op_q)
            pba_pkg::OP_ALLOC: begin
              if (found) begin
                hint_q     <= addr_q;
                res_page_q <= pba_pkg::page_t'({addr_q, lcb});
                done_q     <= 1'b1;
                state_q    <= S_IDLE;
              end else if (last) begin
                status_q <= pba_pkg::ST_NO_FREE;
                done_q   <= 1'b1;
                state_q  <= S_IDLE;
              end else begin
                addr_q <= addr_next;
                cnt_q  <= cnt_q + 1'b1;
              end
            end
            pba_pkg::OP_FREE: begin
              if (target_set) begin
                if (addr_q < hint_q) begin
                  hint_q <= addr_q;
                end
              end else begin
                status_q <= pba_pkg::ST_NOT_USED;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o           = done_q;
  assign page_index_res_o = res_page_q;
  assign status_o         = status_q;

endmodule

// File: rtl/page_bitmap_allocator_top.sv
`timescale 1ns / 1ps

// Next-fit physical page allocator over a bitmap with one used bit per page.
// A command transaction is taken at a rising edge where start_i is high and
// busy_o is low; op_i selects allocate, checked free, mark free or mark used,
// and page_index_i names the page for the last three.
// Each command yields exactly one result: done_o is high for one cycle with
// page_index_res_o and status_o valid in that cycle. The receiver cannot stall,
// so the result is simply taken in that cycle.
// Free and mark commands do one bitmap read, then the write-back as the
// result is registered. Allocate scans words from the hint up to the first
// word with a clear bit; the scan reads one bitmap word per cycle from the
// bitmap RAM and covers all MAP_WORDS words when the map is full. A new
// command may be started in the cycle in which done_o is high.
// After reset the bitmap RAM is swept to all ones, one word per cycle, and
// busy_o stays high during the sweep, before the first command is taken.
// The search hint resets to word zero.
module page_bitmap_allocator_top #(
  parameter int MAP_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pba_pkg::op_t        op_i,
  input  pba_pkg::page_t      page_index_i,
  output logic                busy_o,
  output logic                done_o,
  output pba_pkg::page_t      page_index_res_o,
  output pba_pkg::status_t    status_o
);

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);

  // Power-up sweep state: the RAM has no reset of its own.
  logic           init_q;
  logic [AW-1:0]  init_cnt_q;

  logic           ctrl_busy;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  pba_pkg::word_t rd_data;
  logic           ctrl_wr_en;
  logic [AW-1:0]  ctrl_wr_addr;
  pba_pkg::word_t ctrl_wr_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  pba_pkg::word_t wr_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_cnt_q <= '0;
    end else if (init_q) begin
      init_cnt_q <= init_cnt_q + 1'b1;
      if (init_cnt_q == LAST_ADDR) begin
        init_q <= 1'b0;
      end
    end
  end

  // During the sweep the write port belongs to the sweep counter.
  assign wr_en   = init_q | ctrl_wr_en;
  assign wr_addr = init_q ? init_cnt_q : ctrl_wr_addr;
  assign wr_data = init_q ? pba_pkg::FULL_WORD : ctrl_wr_data;

  assign busy_o = init_q | ctrl_busy;

  pba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pba_ctrl #(
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (!init_q),
    .start_i          (start_i),
    .op_i             (op_i),
    .page_index_i     (page_index_i),
    .busy_o           (ctrl_busy),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_en_o          (ctrl_wr_en),
    .wr_addr_o        (ctrl_wr_addr),
    .wr_data_o        (ctrl_wr_data),
    .done_o           (done_o),
    .page_index_res_o (page_index_res_o),
    .status_o         (status_o)
  );

endmodule

// File: tb/page_bitmap_allocator_top_test.sv
`timescale 1ns / 1ps

// Testbench for the next-fit page allocator. Each command transaction is
// pushed through a small predictor that keeps its own copy of the used-page
// bitmap and the search hint. The predictor runs at the moment the command is
// accepted, so the queue of pending results is always in command order. A
// checker compares every done_o cycle against the oldest pending result.
module page_bitmap_allocator_top_test;
  import pba_pkg::*;

  localparam int MAP_WORDS = 1024;
  // Highest page number the map covers. With 1024 words this is exactly the
  // top of the 15-bit page field, so every page number lands inside the map.
  localparam int LAST_PAGE = MAP_WORDS * WORD_BITS - 1;
  // Pages in the first 16 words form a busy working area for random traffic.
  localparam int HOT_PAGES = 16 * WORD_BITS;

  typedef struct packed {
    page_t   page;
    status_t status;
  } page_result_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start_i;
  op_t     op_i;
  page_t   page_index_i;
  logic    busy_o;
  logic    done_o;
  page_t   page_index_res_o;
  status_t status_o;

  // Predicted allocator state: one used bit per page, and the word where the
  // next allocate starts its scan.
  word_t page_map [MAP_WORDS];
  int    search_word;

  page_result_t pending_page_results[$];
  // Pages handed out by allocate, so that most checked frees name a page that
  // is really in use and the bitmap keeps turning over.
  page_t        owned_pages[$];
  int           mismatch_count;

  page_bitmap_allocator_top #(
    .MAP_WORDS(MAP_WORDS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .op_i            (op_i),
    .page_index_i    (page_index_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .page_index_res_o(page_index_res_o),
    .status_o        (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one command to the predicted state and returns the result the
  // block must report for it.
  function automatic page_result_t predict_page_result(op_t op, page_t page);
    page_result_t r;
    int           w;
    int           b;
    int           idx;
    bit           found;
    r.page   = '0;
    r.status = ST_OK;
    w        = int'(page) / WORD_BITS;
    b        = int'(page) % WORD_BITS;
    found    = 1'b0;
    case (op)
      OP_ALLOC: begin
        // Scan from the hint with wraparound; the first word with any clear
        // bit gives up its lowest clear bit.
        for (int j = 0; j < MAP_WORDS && !found; j++) begin
          idx = (search_word + j) % MAP_WORDS;
          if (page_map[idx] != FULL_WORD) begin
            b = 0;
            while (page_map[idx][b]) b++;
            page_map[idx][b] = 1'b1;
            search_word      = idx;
            r.page           = page_t'(idx * WORD_BITS + b);
            found            = 1'b1;
          end
        end
        if (!found) r.status = ST_NO_FREE;
      end
      OP_FREE: begin
        // A checked free only succeeds on a page that is in use, and pulls
        // the hint down so the freed page is found early.
        if (w < MAP_WORDS && page_map[w][b]) begin
          page_map[w][b] = 1'b0;
          if (w < search_word) search_word = w;
        end else begin
          r.status = ST_NOT_USED;
        end
      end
      OP_MARK_FREE: begin
        if (w < MAP_WORDS) page_map[w][b] = 1'b0;
      end
      default: begin
        if (w < MAP_WORDS) page_map[w][b] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Drives one command from the falling edge and holds it until a rising edge
  // finds the block not busy. That edge is the transaction.
  task automatic send_command(op_t op, page_t page);
    page_result_t want;
    @(negedge clk_i);
    start_i      <= 1'b1;
    op_i         <= op;
    page_index_i <= page;
    do @(posedge clk_i); while (busy_o);
    want = predict_page_result(op, page);
    pending_page_results.push_back(want);
    if (op == OP_ALLOC && want.status == ST_OK) owned_pages.push_back(want.page);
  endtask

  // Random idle time between commands: mostly none or a few cycles, now and
  // then a long stretch. When no gap is drawn, start_i simply stays high and
  // the next command follows back to back.
  task automatic pause_commands();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 45) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 80);
    if (n > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_and_pause(op_t op, page_t page);
    send_command(op, page);
    pause_commands();
  endtask

  // Right after reset every page is marked used. Allocate must report that
  // nothing is free after scanning the whole map; page zero then goes through
  // a free, a double free and an allocate like any other page.
  task automatic test_full_map_and_page_zero();
    send_and_pause(OP_ALLOC, page_t'(LAST_PAGE));
    send_and_pause(OP_FREE, '0);
    send_and_pause(OP_FREE, '0);
    send_and_pause(OP_ALLOC, '0);
    send_and_pause(OP_ALLOC, '0);
  endtask

  // Pages at both ends of the map and at alternating bit patterns. This moves
  // the hint to the last word, wraps the scan back to word zero, and checks
  // that a checked free lowers the hint while a mark free leaves it alone.
  task automatic test_hint_and_wraparound();
    send_and_pause(OP_MARK_FREE, page_t'(LAST_PAGE));
    send_and_pause(OP_ALLOC, '0);
    send_and_pause(OP_MARK_FREE, '0);
    send_and_pause(OP_ALLOC, page_t'(LAST_PAGE));
    send_and_pause(OP_FREE, page_t'(LAST_PAGE));
    send_and_pause(OP_FREE, page_t'(LAST_PAGE));
    send_and_pause(OP_MARK_USED, page_t'(LAST_PAGE));
    send_and_pause(OP_MARK_FREE, 15'h5555);
    send_and_pause(OP_MARK_FREE, 15'h2AAA);
    send_and_pause(OP_ALLOC, '0);
    send_and_pause(OP_FREE, 15'h5555);
    send_and_pause(OP_ALLOC, 15'h7FFF);
    send_and_pause(OP_FREE, 15'h2AAA);
    send_and_pause(OP_ALLOC, '0);
  endtask

  // Several clear bits in one word must come out lowest first, including the
  // top bit of the word.
  task automatic test_lowest_clear_bit();
    send_and_pause(OP_MARK_FREE, page_t'(100 * WORD_BITS + 31));
    send_and_pause(OP_MARK_FREE, page_t'(100 * WORD_BITS + 7));
    send_and_pause(OP_MARK_FREE, page_t'(100 * WORD_BITS));
    send_and_pause(OP_ALLOC, '0);
    send_and_pause(OP_ALLOC, '0);
    send_and_pause(OP_ALLOC, '0);
  endtask

  // Mostly pages in a small working area so that allocate scans stay short,
  // with some pages from anywhere in the map so every page bit toggles.
  function automatic page_t pick_page();
    if ($urandom_range(0, 4) == 0) return page_t'($urandom_range(0, LAST_PAGE));
    return page_t'($urandom_range(0, HOT_PAGES - 1));
  endfunction

  // Random mix of all four commands. Most checked frees return a page that an
  // earlier allocate handed out; the rest hit arbitrary pages and so also
  // exercise the not-in-use path. Some blocks of commands run with no gaps.
  task automatic test_random_traffic(int count);
    int    r;
    int    k;
    op_t   op;
    page_t page;
    bit    steady;
    steady = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_ALLOC;
      else if (r < 65) op = OP_FREE;
      else if (r < 88) op = OP_MARK_FREE;
      else op = OP_MARK_USED;
      page = pick_page();
      if (op == OP_ALLOC) begin
        // The page field is a don't-care here; random bits make sure the
        // block really ignores it.
        page = page_t'($urandom);
      end else if (op == OP_FREE && owned_pages.size() > 0 && $urandom_range(0, 9) < 7) begin
        k    = $urandom_range(0, owned_pages.size() - 1);
        page = owned_pages[k];
        owned_pages.delete(k);
      end
      send_command(op, page);
      if (!steady) pause_commands();
    end
  endtask

  task automatic note_mismatch(string what, page_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected page %0d status %0d, got page %0d status %0d",
               $realtime, what, want.page, want.status, page_index_res_o, status_o);
    end
  endtask

  // Every done_o cycle carries one result and is consumed at this edge.
  always @(posedge clk_i) begin : result_check
    page_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_page_results.size() == 0) begin
        want = '0;
        note_mismatch("result with no command pending", want);
      end else begin
        want = pending_page_results.pop_front();
        if (page_index_res_o !== want.page || status_o !== want.status) begin
          note_mismatch("result mismatch", want);
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    op_i           = OP_ALLOC;
    page_index_i   = '0;
    mismatch_count = 0;
    foreach (page_map[i]) page_map[i] = FULL_WORD;
    search_word = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block sweeps its bitmap after reset; send_command simply waits for
    // busy_o to drop before the first transaction goes through.
    test_full_map_and_page_zero();
    test_hint_and_wraparound();
    test_lowest_clear_bit();
    test_random_traffic(1250);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_page_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Even if every command scanned the whole map, the run stays well inside
  // this bound.
  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

endmodule
